@@ rtl/sfa_pkg.sv @@
// Package for the segregated-fit block allocator.
// Status and request codes, fixed field widths. No dependencies.
`timescale 1ns / 1ps

package sfa_pkg;

   localparam int REQ_TYPE_W   = 1;
   localparam int REQ_BYTES_W  = 12;
   localparam int ADDR_W       = 16;
   localparam int STATUS_W     = 2;
   localparam int GRANT_W      = 12;
   localparam int TOTAL_W      = 17;
   localparam int PAGES_W      = 5;
   localparam int LIMIT_W      = 5;
   localparam int NEED_W       = 14;
   localparam int GRAN_SHIFT   = 4;
   localparam int COUNT_W      = 8;

   localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_PAGES = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID_FREE = 2'd3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

endpackage

@@ rtl/sfa_if.sv @@
// Request and response channel interfaces of the allocator.
// Depends on sfa_pkg for field widths.
`timescale 1ns / 1ps

interface sfa_req_if import sfa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [REQ_TYPE_W-1:0]  req_type;
   logic [REQ_BYTES_W-1:0] request_bytes;
   logic [ADDR_W-1:0]      block_address;

   modport source (output valid, req_type, request_bytes, block_address, input ready);
   modport sink   (input valid, req_type, request_bytes, block_address, output ready);
endinterface

interface sfa_rsp_if import sfa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   result_address;
   logic [GRANT_W-1:0]  granted_bytes;
   logic [TOTAL_W-1:0]  bytes_in_use;
   logic [PAGES_W-1:0]  pages_in_use;

   modport source (output valid, status, result_address, granted_bytes, bytes_in_use,
                   pages_in_use, input ready);
   modport sink   (input valid, status, result_address, granted_bytes, bytes_in_use,
                   pages_in_use, output ready);
endinterface

@@ rtl/segregated_fit_block_allocator.sv @@
// Segregated-fit sub-page block allocator, top level.
// Depends on sfa_pkg and the channel interfaces in sfa_if.sv.
//
// One request at a time under a small sequencer over registered block RAMs
// (granule flags, sizes, free-list links, class heads, page counts). After
// reset a clearing pass over all NUM_PAGES*PAGE_BYTES/16 granules (4096 by
// default) runs before the first request is taken. An allocate scans the size
// classes upward from the request's own class (up to PAGE_BYTES/16 classes)
// and, when no list block fits, searches the pages (up to NUM_PAGES). When a
// free releases the last allocated block of its page, the sequencer walks every
// block in that page. The response sits in an output register so a new request
// can be taken while it waits.
// PAGE_BYTES must be a power of two.
`timescale 1ns / 1ps

module segregated_fit_block_allocator import sfa_pkg::*; #(
   parameter int NUM_PAGES          = 16,
   parameter int PAGE_BYTES         = 4096,
   parameter int BLOCK_HEADER_BYTES = 16,
   parameter int PAGE_HEADER_BYTES  = 20
) (
   input  logic               clock,
   input  logic               reset,
   sfa_req_if.sink            req_chan,
   sfa_rsp_if.source          rsp_chan,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data
);

   localparam int GPP       = PAGE_BYTES / 16;
   localparam int KW        = $clog2(GPP);
   localparam int NGRAN     = NUM_PAGES * GPP;
   localparam int GW        = $clog2(NGRAN);
   localparam int GW1       = GW + 1;
   localparam int LW        = GW + 1;
   localparam int KW1       = KW + 1;
   localparam int PW        = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int PW1       = PW + 1;
   localparam int PCW       = $clog2(NUM_PAGES + 1);
   localparam int SW        = $clog2(PAGE_BYTES);
   localparam int CW        = KW;
   localparam int PBW       = $clog2(PAGE_BYTES);
   localparam int FIRST_OFF = PAGE_HEADER_BYTES - BLOCK_HEADER_BYTES;
   localparam int MAX_BLOCK = PAGE_BYTES - FIRST_OFF;
   localparam int MAX_ALLOC = PAGE_BYTES - PAGE_HEADER_BYTES;
   localparam int MIN_BLOCK = BLOCK_HEADER_BYTES + 16;
   localparam logic [LW-1:0] LINK_NONE = LW'(NGRAN);

   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_ABEGIN = 5'd2;
   localparam logic [4:0] S_SCAN   = 5'd3;
   localparam logic [4:0] S_RDG    = 5'd4;
   localparam logic [4:0] S_UNL    = 5'd5;
   localparam logic [4:0] S_PAGE   = 5'd6;
   localparam logic [4:0] S_SPLIT  = 5'd7;
   localparam logic [4:0] S_SPLIT2 = 5'd8;
   localparam logic [4:0] S_PRD    = 5'd9;
   localparam logic [4:0] S_PWR    = 5'd10;
   localparam logic [4:0] S_PWR2   = 5'd11;
   localparam logic [4:0] S_AFIN   = 5'd12;
   localparam logic [4:0] S_FBEGIN = 5'd13;
   localparam logic [4:0] S_FRD    = 5'd14;
   localparam logic [4:0] S_FCHK   = 5'd15;
   localparam logic [4:0] S_FAFTER = 5'd16;
   localparam logic [4:0] S_WRD    = 5'd17;
   localparam logic [4:0] S_WEV    = 5'd18;
   localparam logic [4:0] S_OUT    = 5'd19;

   // flags: [1] block start, [0] block free
   logic [1:0]         flag_mem [NGRAN];
   logic [SW-1:0]      size_mem [NGRAN];
   logic [LW-1:0]      next_mem [NGRAN];
   logic [LW-1:0]      prev_mem [NGRAN];
   logic [LW-1:0]      head_mem [GPP];
   logic [COUNT_W-1:0] cnt_mem  [NUM_PAGES];

   logic [1:0]         flag_rd;
   logic [SW-1:0]      size_rd;
   logic [LW-1:0]      next_rd, prev_rd, head_rd;
   logic [COUNT_W-1:0] cnt_rd;

   logic               meta_we, next_we, prev_we, head_we, cnt_we;
   logic [GW-1:0]      meta_wa, next_wa, prev_wa;
   logic [CW-1:0]      head_wa, head_ra;
   logic [1:0]         flag_wd;
   logic [SW-1:0]      size_wd;
   logic [LW-1:0]      next_wd, prev_wd, head_wd;
   logic [COUNT_W-1:0] cnt_wd;

   logic [4:0]            state_ff, state_in;
   logic [GW-1:0]         clr_ff;
   logic                  op_free_ff;
   logic [NEED_W-1:0]     need_raw_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [SW-1:0]         need_ff, bsize_ff, rem_ff;
   logic [GW-1:0]         g_ff, push_g_ff;
   logic [CW-1:0]         push_c_ff, scan_ff, chk_ff;
   logic                  chk_v_ff;
   logic [PW-1:0]         page_ff;
   logic [PW1-1:0]        pg_ff;
   logic [KW-1:0]         k_ff;
   logic [COUNT_W-1:0]    cnt_ff;
   logic                  busy_ff [NUM_PAGES];
   logic [PCW-1:0]        pages_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic [LIMIT_W-1:0]    limit_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;
   logic [GRANT_W-1:0]    rsp_grant_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;
   logic [PAGES_W-1:0]    rsp_pages_ff;

   logic [NEED_W-1:0] need_w;
   int                lim_i;
   logic [16:0]       f_start, f_page, f_off, f_rel;
   logic              f_bad;
   logic [GW-1:0]     f_g;
   logic [GW1-1:0]    sp_ng;
   logic [SW-1:0]     sp_rem;
   logic              sp_do;
   logic [KW1-1:0]    w_nk;
   logic [SW+1:0]     w_end;
   logic              rsp_free;

   assign need_w = (NEED_W'(req_chan.request_bytes) + NEED_W'(BLOCK_HEADER_BYTES + 15))
                   & ~NEED_W'(15);
   assign lim_i  = (int'(limit_ff) < NUM_PAGES) ? int'(limit_ff) : NUM_PAGES;

   assign f_start = {1'b0, addr_ff} - 17'(BLOCK_HEADER_BYTES);
   assign f_page  = f_start >> PBW;
   assign f_off   = f_start & 17'(PAGE_BYTES - 1);
   assign f_rel   = f_off - 17'(FIRST_OFF);
   assign f_bad   = (addr_ff < ADDR_W'(BLOCK_HEADER_BYTES)) || (int'(f_page) >= NUM_PAGES)
                    || !busy_ff[f_page[PW-1:0]] || (f_off < 17'(FIRST_OFF))
                    || (f_rel[3:0] != 4'd0);
   assign f_g     = GW'((32'(f_page) << KW) + 32'(f_rel >> GRAN_SHIFT));

   assign sp_ng  = GW1'(g_ff) + GW1'(need_ff >> GRAN_SHIFT);
   assign sp_rem = bsize_ff - need_ff;
   assign sp_do  = (bsize_ff >= need_ff) && (sp_rem >= SW'(MIN_BLOCK)) && (int'(sp_ng) < NGRAN);
   assign w_nk   = KW1'(k_ff) + KW1'(size_rd >> GRAN_SHIFT);
   // byte end of the walked block within the page data area
   assign w_end  = (SW+2)'({k_ff, 4'b0000}) + (SW+2)'(size_rd);

   assign head_ra = (state_ff == S_SCAN) ? scan_ff : push_c_ff;

   always_ff @(posedge clock) begin
      if (meta_we) begin
         flag_mem[meta_wa] <= flag_wd;
         size_mem[meta_wa] <= size_wd;
      end
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (head_we) head_mem[head_wa] <= head_wd;
      if (cnt_we) cnt_mem[page_ff] <= cnt_wd;
      flag_rd <= flag_mem[g_ff];
      size_rd <= size_mem[g_ff];
      next_rd <= next_mem[g_ff];
      prev_rd <= prev_mem[g_ff];
      head_rd <= head_mem[head_ra];
      cnt_rd  <= cnt_mem[page_ff];
   end

   // memory write ports and next state
   always_comb begin
      state_in = state_ff;
      meta_we  = 1'b0;
      meta_wa  = g_ff;
      flag_wd  = 2'b10;
      size_wd  = bsize_ff;
      next_we  = 1'b0;
      next_wa  = push_g_ff;
      next_wd  = head_rd;
      prev_we  = 1'b0;
      prev_wa  = push_g_ff;
      prev_wd  = LINK_NONE;
      head_we  = 1'b0;
      head_wa  = push_c_ff;
      head_wd  = LW'(push_g_ff);
      cnt_we   = 1'b0;
      cnt_wd   = cnt_ff + COUNT_W'(1);
      unique case (state_ff)
         S_CLEAR: begin
            meta_we = 1'b1;
            meta_wa = clr_ff;
            flag_wd = 2'b00;
            size_wd = '0;
            head_we = (int'(clr_ff) < GPP);
            head_wa = clr_ff[CW-1:0];
            head_wd = LINK_NONE;
            if (clr_ff == GW'(NGRAN - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_chan.valid)
               state_in = (req_chan.req_type == REQ_FREE) ? S_FBEGIN : S_ABEGIN;
         end
         S_ABEGIN: begin
            state_in = (17'(need_raw_ff) > 17'(MAX_ALLOC)) ? S_OUT : S_SCAN;
         end
         S_SCAN: begin
            if (chk_v_ff && head_rd != LINK_NONE) state_in = S_RDG;
            else if (chk_v_ff && chk_ff == CW'(GPP - 1)) state_in = S_PAGE;
         end
         S_RDG: state_in = S_UNL;
         S_UNL, S_WEV: begin
            if (state_ff == S_UNL || flag_rd == 2'b11) begin
               if (prev_rd != LINK_NONE) begin
                  next_we = 1'b1;
                  next_wa = prev_rd[GW-1:0];
                  next_wd = next_rd;
               end else begin
                  head_we = 1'b1;
                  head_wa = CW'(size_rd >> GRAN_SHIFT);
                  head_wd = next_rd;
               end
               if (next_rd != LINK_NONE) begin
                  prev_we = 1'b1;
                  prev_wa = next_rd[GW-1:0];
                  prev_wd = prev_rd;
               end
            end
            if (state_ff == S_UNL) begin
               state_in = S_SPLIT;
            end else begin
               meta_we  = 1'b1;
               flag_wd  = 2'b00;
               size_wd  = size_rd;
               state_in = (int'(w_end) >= MAX_BLOCK) ? S_OUT : S_WRD;
            end
         end
         S_PAGE: begin
            if (int'(pg_ff) >= lim_i) state_in = S_OUT;
            else if (!busy_ff[pg_ff[PW-1:0]]) state_in = S_SPLIT;
         end
         S_SPLIT: begin
            meta_we  = 1'b1;
            size_wd  = sp_do ? need_ff : bsize_ff;
            state_in = sp_do ? S_SPLIT2 : S_AFIN;
         end
         S_SPLIT2: begin
            meta_we  = 1'b1;
            meta_wa  = push_g_ff;
            flag_wd  = 2'b11;
            size_wd  = rem_ff;
            state_in = S_PWR;
         end
         S_PRD: state_in = S_PWR;
         S_PWR: begin
            next_we = 1'b1;
            head_we = 1'b1;
            if (head_rd != LINK_NONE) begin
               prev_we = 1'b1;
               prev_wa = head_rd[GW-1:0];
               prev_wd = LW'(push_g_ff);
            end
            state_in = S_PWR2;
         end
         S_PWR2: begin
            prev_we  = 1'b1;
            state_in = op_free_ff ? S_FAFTER : S_AFIN;
         end
         S_AFIN: begin
            cnt_we   = 1'b1;
            state_in = S_OUT;
         end
         S_FBEGIN: state_in = f_bad ? S_OUT : S_FRD;
         S_FRD:    state_in = S_FCHK;
         S_FCHK: begin
            if (flag_rd != 2'b10) begin
               state_in = S_OUT;
            end else begin
               meta_we  = 1'b1;
               flag_wd  = 2'b11;
               size_wd  = size_rd;
               state_in = S_PRD;
            end
         end
         S_FAFTER: begin
            if (cnt_ff <= COUNT_W'(1)) begin
               state_in = S_WRD;
            end else begin
               cnt_we   = 1'b1;
               cnt_wd   = cnt_ff - COUNT_W'(1);
               state_in = S_OUT;
            end
         end
         S_WRD: state_in = S_WEV;
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         chk_v_ff     <= 1'b0;
         pages_ff     <= '0;
         total_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_PAGES; i++) busy_ff[i] <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) limit_ff <= csr_write_data;
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_chan.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: clr_ff <= clr_ff + GW'(1);
            S_IDLE: begin
               op_free_ff  <= (req_chan.req_type == REQ_FREE);
               need_raw_ff <= need_w;
               addr_ff     <= req_chan.block_address;
            end
            S_ABEGIN: begin
               status_ff <= STATUS_TOO_LARGE;
               need_ff   <= SW'(need_raw_ff);
               scan_ff   <= CW'(need_raw_ff >> GRAN_SHIFT);
               chk_v_ff  <= 1'b0;
            end
            S_SCAN: begin
               if (chk_v_ff && head_rd != LINK_NONE) begin
                  g_ff    <= head_rd[GW-1:0];
                  page_ff <= PW'(head_rd >> KW);
               end else if (chk_v_ff && chk_ff == CW'(GPP - 1)) begin
                  pg_ff <= '0;
               end else begin
                  chk_ff   <= scan_ff;
                  chk_v_ff <= 1'b1;
                  if (scan_ff != CW'(GPP - 1)) scan_ff <= scan_ff + CW'(1);
               end
            end
            S_UNL: begin
               bsize_ff <= size_rd;
               cnt_ff   <= cnt_rd;
            end
            S_PAGE: begin
               status_ff <= STATUS_OUT_OF_PAGES;
               if (int'(pg_ff) < lim_i) begin
                  if (!busy_ff[pg_ff[PW-1:0]]) begin
                     busy_ff[pg_ff[PW-1:0]] <= 1'b1;
                     pages_ff <= pages_ff + PCW'(1);
                     page_ff  <= pg_ff[PW-1:0];
                     g_ff     <= GW'(32'(pg_ff) << KW);
                     bsize_ff <= SW'(MAX_BLOCK);
                     cnt_ff   <= '0;
                  end else begin
                     pg_ff <= pg_ff + PW1'(1);
                  end
               end
            end
            S_SPLIT: begin
               if (sp_do) begin
                  bsize_ff  <= need_ff;
                  rem_ff    <= sp_rem;
                  push_g_ff <= sp_ng[GW-1:0];
                  push_c_ff <= CW'(sp_rem >> GRAN_SHIFT);
               end
            end
            S_AFIN: begin
               total_ff  <= total_ff + TOTAL_W'(bsize_ff);
               status_ff <= STATUS_OK;
            end
            S_FBEGIN: begin
               status_ff <= STATUS_INVALID_FREE;
               g_ff      <= f_g;
               page_ff   <= f_page[PW-1:0];
            end
            S_FCHK: begin
               if (flag_rd == 2'b10) begin
                  total_ff  <= total_ff - TOTAL_W'(size_rd);
                  bsize_ff  <= size_rd;
                  cnt_ff    <= cnt_rd;
                  push_g_ff <= g_ff;
                  push_c_ff <= CW'(size_rd >> GRAN_SHIFT);
               end
            end
            S_FAFTER: begin
               status_ff <= STATUS_OK;
               if (cnt_ff <= COUNT_W'(1)) begin
                  k_ff <= '0;
                  g_ff <= GW'(32'(page_ff) << KW);
               end
            end
            S_WEV: begin
               if (int'(w_end) >= MAX_BLOCK) begin
                  busy_ff[page_ff] <= 1'b0;
                  pages_ff <= pages_ff - PCW'(1);
               end else begin
                  k_ff <= w_nk[KW-1:0];
                  g_ff <= g_ff + GW'(size_rd >> GRAN_SHIFT);
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_free = op_free_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= (status_ff == STATUS_OK && !rsp_free)
                          ? ADDR_W'((32'(g_ff) << GRAN_SHIFT) + FIRST_OFF + BLOCK_HEADER_BYTES)
                          : '0;
         rsp_grant_ff  <= (status_ff == STATUS_OK) ? GRANT_W'(bsize_ff) : '0;
         rsp_total_ff  <= total_ff;
         rsp_pages_ff  <= PAGES_W'(pages_ff);
      end
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.result_address = rsp_addr_ff;
   assign rsp_chan.granted_bytes  = rsp_grant_ff;
   assign rsp_chan.bytes_in_use   = rsp_total_ff;
   assign rsp_chan.pages_in_use   = rsp_pages_ff;

endmodule
